@@ hdl/ftcr_pkg.sv @@
// Shared field widths, operation and status codes, and the result word layout.
`timescale 1ns / 1ps

package ftcr_pkg;

    // Widths of the input fields.
    localparam int unsigned OP_W    = 2;
    localparam int unsigned MACH_W  = 3;
    localparam int unsigned ST_W    = 4;
    localparam int unsigned CNT_W   = 5;

    // Widths of the result fields.
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OUTCNT_W = 32;
    localparam int unsigned SATN_W   = 2;
    localparam int unsigned COVS_W   = 8;
    localparam int unsigned COVT_W   = 12;

    // Stream word widths, padded to whole bytes.
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 96;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_OBSERVE    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_COUNT  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_LEGAL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OWNERSHIP = 3'd1,
        ST_BAD_LEGAL = 3'd2,
        ST_DUP_LEGAL = 3'd3,
        ST_RESOURCE  = 3'd4
    } t_status;

    // Packed so that the first member listed last lands in the lowest bits.
    typedef struct packed {
        logic [COVT_W-1:0]   cov_trans;
        logic [COVS_W-1:0]   cov_states;
        logic [SATN_W-1:0]   sat_now;
        logic [OUTCNT_W-1:0] trans_count;
        logic [OUTCNT_W-1:0] visit_count;
        logic                illegal;
        logic                had_previous;
        t_status             status;
    } t_result;

endpackage

@@ hdl/ftcr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ftcr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fsm_transition_coverage_recorder.sv @@
// Top level of the state machine state and transition coverage recorder.
`timescale 1ns / 1ps

// Usage.
// The slave stream carries one command word per handshake: observe a state of a
// machine, set a machine's state count, or mark a legal transition. The master
// stream returns exactly one result word per command, in order, with status,
// the updated visit and transition counters and the running covered totals.
// Visit counters live in one RAM (one entry per machine and state); legal
// marks, transition counters and their sticky flags share a second RAM (one
// entry per machine, source and destination state). Per-machine state counts,
// previous states and illegal counters sit in flip-flops.
// Both RAMs are read as a word is accepted; the update state then modifies,
// writes back and loads the result register, and no new word is taken until
// that update completes. The read of one word follows the write of the
// previous one, so no forwarding is needed.
// After reset the block sweeps the transition RAM (and the visit RAM with it)
// to zero, entry by entry, with
// o_s_tready low. A stalled result register holds its word; the next command
// is still accepted and waits in the update cycle until the register frees.

module fsm_transition_coverage_recorder
    import ftcr_pkg::*;
#(
    parameter int unsigned MACHINES   = 8,
    parameter int unsigned STATES     = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Command words.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // op[1:0], machine[4:2], state[8:5], src_state[12:9], num_states[17:13]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Result words.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[2:0], had_previous[3], illegal[4], visit_count[36:5],
    // transition_count[68:37], saturated_now[70:69], covered_states[78:71],
    // covered_transitions[90:79]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int unsigned NBINS  = MACHINES * STATES;
    localparam int unsigned NPAIRS = MACHINES * STATES * STATES;
    localparam int unsigned MW     = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int unsigned BAW    = $clog2(NBINS);
    localparam int unsigned PAW    = $clog2(NPAIRS);
    localparam int unsigned VW     = COUNT_BITS + 1;   // sticky flag and counter
    localparam int unsigned PW     = COUNT_BITS + 2;   // legal, sticky flag, counter
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state                r_state, n_state;
    logic [PAW-1:0]        r_clr;
    logic [OP_W-1:0]       r_op;
    logic [MACH_W-1:0]     r_m;
    logic [ST_W-1:0]       r_st;
    logic [ST_W-1:0]       r_from;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_ms         [MACHINES];
    logic [ST_W-1:0]       r_last_state [MACHINES];
    logic [COUNT_BITS-1:0] r_ill_hits   [MACHINES];
    logic [MACHINES-1:0]   r_last_valid;
    logic [MACHINES-1:0]   r_ill_sat;
    logic [COVS_W-1:0]     r_cov_states;
    logic [COVT_W-1:0]     r_cov_trans;
    logic                  r_out_valid;
    t_result               r_out;

    // Input field decode.
    logic [OP_W-1:0]   in_op;
    logic [MACH_W-1:0] in_m;
    logic [ST_W-1:0]   in_st;
    logic [ST_W-1:0]   in_from;
    logic [CNT_W-1:0]  in_cnt;
    logic              in_acc;

    assign in_op   = i_s_tdata[1:0];
    assign in_m    = i_s_tdata[4:2];
    assign in_st   = i_s_tdata[8:5];
    assign in_from = i_s_tdata[12:9];
    assign in_cnt  = i_s_tdata[17:13];
    assign in_acc  = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == S_IDLE);

    // RAM addressing: from the incoming word while idle, from the held word after.
    logic [OP_W-1:0]   f_op;
    logic [MACH_W-1:0] f_m;
    logic [ST_W-1:0]   f_st;
    logic [ST_W-1:0]   f_pf;
    logic [BAW-1:0]    v_addr;
    logic [PAW-1:0]    p_addr;

    always_comb begin
        f_op = (r_state == S_IDLE) ? in_op : r_op;
        f_m  = (r_state == S_IDLE) ? in_m  : r_m;
        f_st = (r_state == S_IDLE) ? in_st : r_st;
        if (f_op == OP_MARK_LEGAL) begin
            f_pf = (r_state == S_IDLE) ? in_from : r_from;
        end else begin
            f_pf = r_last_state[MW'(f_m)];
        end
        v_addr = BAW'(32'(f_m) * STATES + 32'(f_st));
        p_addr = PAW'((32'(f_m) * STATES + 32'(f_pf)) * STATES + 32'(f_st));
    end

    logic [VW-1:0] v_rdata, v_wdata;
    logic [PW-1:0] p_rdata, p_wdata;
    logic          v_we, p_we;
    logic [BAW-1:0] v_waddr;
    logic [PAW-1:0] p_waddr;

    ftcr_ram #(.WIDTH(VW), .DEPTH(NBINS)) u_visit_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_addr),
        .o_rdata (v_rdata)
    );

    ftcr_ram #(.WIDTH(PW), .DEPTH(NPAIRS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_addr),
        .o_rdata (p_rdata)
    );

    // Update of the held word against the RAM read data.
    logic [MW-1:0]         mi;
    logic                  m_ok;
    logic [CNT_W-1:0]      ms;
    logic                  prev;
    logic [COUNT_BITS-1:0] vhits, v_new;
    logic                  vsat, v_max, v_evt;
    logic [COUNT_BITS-1:0] phits, p_new;
    logic                  psat, plegal, p_max, p_evt;
    logic [COUNT_BITS-1:0] ihits, i_new;
    logic                  isat, i_max, i_evt;
    logic                  exec_go;
    logic                  vis_upd, pair_upd, pair_mark, ill_upd, ms_upd, last_upd;
    logic                  cs_inc, ct_inc;
    t_result               res;

    always_comb begin
        mi     = MW'(r_m);
        m_ok   = 32'(r_m) < MACHINES;
        ms     = r_ms[mi];
        prev   = r_last_valid[mi];
        vhits  = v_rdata[COUNT_BITS-1:0];
        vsat   = v_rdata[COUNT_BITS];
        v_max  = (vhits == CMAX);
        v_new  = v_max ? vhits : vhits + COUNT_BITS'(1);
        v_evt  = v_max && !vsat;
        phits  = p_rdata[COUNT_BITS-1:0];
        psat   = p_rdata[COUNT_BITS];
        plegal = p_rdata[COUNT_BITS+1];
        p_max  = (phits == CMAX);
        p_new  = p_max ? phits : phits + COUNT_BITS'(1);
        p_evt  = p_max && !psat;
        ihits  = r_ill_hits[mi];
        isat   = r_ill_sat[mi];
        i_max  = (ihits == CMAX);
        i_new  = i_max ? ihits : ihits + COUNT_BITS'(1);
        i_evt  = i_max && !isat;
        exec_go = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

        vis_upd   = 1'b0;
        pair_upd  = 1'b0;
        pair_mark = 1'b0;
        ill_upd   = 1'b0;
        ms_upd    = 1'b0;
        last_upd  = 1'b0;
        cs_inc    = 1'b0;
        ct_inc    = 1'b0;
        res        = '0;
        res.status = ST_OK;

        unique case (r_op)
            OP_OBSERVE: begin
                if (!m_ok || ms == '0 || {1'b0, r_st} >= ms) begin
                    res.status = ST_OWNERSHIP;
                end else begin
                    vis_upd         = 1'b1;
                    last_upd        = 1'b1;
                    cs_inc          = (vhits == '0);
                    res.visit_count = OUTCNT_W'(v_new);
                    if (prev) begin
                        res.had_previous = 1'b1;
                        if (plegal) begin
                            pair_upd        = 1'b1;
                            ct_inc          = (phits == '0);
                            res.trans_count = OUTCNT_W'(p_new);
                            res.sat_now     = {1'b0, v_evt} + {1'b0, p_evt};
                        end else begin
                            ill_upd         = 1'b1;
                            res.illegal     = 1'b1;
                            res.trans_count = OUTCNT_W'(i_new);
                            res.sat_now     = {1'b0, v_evt} + {1'b0, i_evt};
                        end
                    end else begin
                        res.sat_now = {1'b0, v_evt};
                    end
                end
            end
            OP_SET_COUNT: begin
                if (!m_ok || r_cnt == CNT_W'(1) || 32'(r_cnt) > STATES) begin
                    res.status = ST_RESOURCE;
                end else begin
                    ms_upd = 1'b1;
                end
            end
            OP_MARK_LEGAL: begin
                if (!m_ok || ms == '0 || {1'b0, r_st} >= ms || {1'b0, r_from} >= ms) begin
                    res.status = ST_BAD_LEGAL;
                end else if (plegal) begin
                    res.status = ST_DUP_LEGAL;
                end else begin
                    pair_mark = 1'b1;
                end
            end
            default: begin
                // The unused code leaves everything as it is.
            end
        endcase

        res.cov_states = r_cov_states + COVS_W'(cs_inc);
        res.cov_trans  = r_cov_trans + COVT_W'(ct_inc);
    end

    // RAM write ports: zero sweep after reset, otherwise write-back of the update.
    always_comb begin
        if (r_state == S_CLEAR) begin
            v_we    = 32'(r_clr) < NBINS;
            v_waddr = BAW'(r_clr);
            v_wdata = '0;
            p_we    = 1'b1;
            p_waddr = r_clr;
            p_wdata = '0;
        end else begin
            v_we    = exec_go && vis_upd;
            v_waddr = v_addr;
            v_wdata = {vsat | v_max, v_new};
            p_we    = exec_go && (pair_upd || pair_mark);
            p_waddr = p_addr;
            p_wdata = pair_mark ? {1'b1, psat, phits} : {plegal, psat | p_max, p_new};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == PAW'(NPAIRS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_last_valid <= '0;
            r_ill_sat    <= '0;
            r_cov_states <= '0;
            r_cov_trans  <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MACHINES; i++) begin
                r_ms[i]         <= '0;
                r_last_state[i] <= '0;
                r_ill_hits[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + PAW'(1);
            end
            if (in_acc) begin
                r_op   <= in_op;
                r_m    <= in_m;
                r_st   <= in_st;
                r_from <= in_from;
                r_cnt  <= in_cnt;
            end
            if (exec_go) begin
                r_out_valid  <= 1'b1;
                r_out        <= res;
                r_cov_states <= res.cov_states;
                r_cov_trans  <= res.cov_trans;
                if (last_upd) begin
                    r_last_state[mi] <= r_st;
                    r_last_valid[mi] <= 1'b1;
                end
                if (ms_upd) begin
                    r_ms[mi]         <= r_cnt;
                    r_last_state[mi] <= '0;
                    r_last_valid[mi] <= 1'b0;
                end
                if (ill_upd) begin
                    r_ill_hits[mi] <= i_new;
                    r_ill_sat[mi]  <= isat | i_max;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

    // An accepted word always moves on to its update cycle.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted word did not reach the update cycle");

    // Leaving the update cycle always leaves a result in the output register.
    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_EXEC && r_state == S_IDLE) |-> r_out_valid)
        else $error("update finished without a result");

    // Covered totals change only in an update cycle that completes.
    a_totals_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec_go |=> ($stable(r_cov_states) && $stable(r_cov_trans)))
        else $error("covered totals changed outside an update");

    // RAMs are written only during the sweep or a completing update.
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_we || p_we) |-> (r_state == S_CLEAR || exec_go))
        else $error("RAM written outside the sweep or an update");

    // At most two counters can saturate on one word.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.sat_now != 2'd3))
        else $error("impossible saturation count");

endmodule
